FILE: src/half_step_stepper_sequencer_top_macros.svh
// Assertion macros shared by the sequencer checker.
`ifndef HALF_STEP_STEPPER_SEQUENCER_TOP_MACROS_SVH
`define HALF_STEP_STEPPER_SEQUENCER_TOP_MACROS_SVH

// Property checked on every rising edge outside reset.
`define HSS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define HSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/hss_pkg.sv
// ----------------------------------------------------------------------------
// Half-step sequencer package
// Types, mode codes, register indexes and the coil phase table.
// ----------------------------------------------------------------------------
`default_nettype none

package hss_pkg;

  localparam int unsigned BudgetW = 20;
  localparam int unsigned DwellW  = 16;
  localparam int unsigned CountW  = 17;
  localparam int unsigned PosW    = 5;
  localparam int unsigned CoilW   = 4;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [BudgetW-1:0] BudgetReset = BudgetW'(1000);
  localparam logic [DwellW-1:0]  DwellReset  = DwellW'(10);
  localparam logic [PosW-1:0]    PosFirst    = PosW'(1);
  localparam logic [PosW-1:0]    PosLast     = PosW'(16);

  // Motion modes.
  typedef enum logic [ModeW-1:0] {
    MODE_STOP     = 3'd0,
    MODE_BUD_FWD  = 3'd1,
    MODE_BUD_BACK = 3'd2,
    MODE_FREE_FWD = 3'd3,
    MODE_FREE_BACK = 3'd4
  } hss_mode_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_TICK_BUDGET    = 2'd0,
    REG_DWELL_FORWARD  = 2'd1,
    REG_DWELL_BACKWARD = 2'd2
  } hss_reg_e;

  typedef struct packed {
    logic                back_limit_clear;
    logic                fwd_limit_clear;
    logic [ModeW-1:0]    mode_request;
    logic                command;
  } hss_in_t;

  typedef struct packed {
    logic [BudgetW-1:0] ticks_used;
    logic [ModeW-1:0]   active_mode;
    logic [CoilW-1:0]   coils;
  } hss_res_t;

  typedef struct packed {
    logic [BudgetW-1:0] tick_budget;
    logic [DwellW-1:0]  dwell_forward;
    logic [DwellW-1:0]  dwell_backward;
  } hss_cfg_t;

  // Forward half-step phases: A, AB, B, BC, C, CD, D, DA.
  function automatic logic [CoilW-1:0] phase_coils(input logic [2:0] idx);
    logic [CoilW-1:0] c;
    case (idx)
      3'd0:    c = 4'h1;
      3'd1:    c = 4'h3;
      3'd2:    c = 4'h2;
      3'd3:    c = 4'h6;
      3'd4:    c = 4'h4;
      3'd5:    c = 4'hC;
      3'd6:    c = 4'h8;
      3'd7:    c = 4'h9;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: src/hss_cfg.sv
// ----------------------------------------------------------------------------
// Half-step sequencer configuration registers
// Decodes the write port into the budget and dwell threshold registers.
// ----------------------------------------------------------------------------
`default_nettype none

module hss_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [hss_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [hss_pkg::BudgetW-1:0]   cfg_data_i,
  output hss_pkg::hss_cfg_t                  cfg_o
);

  hss_pkg::hss_cfg_t cfg_q, cfg_d;

  // Write decode; an unused index leaves everything as is.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (hss_pkg::hss_reg_e'(cfg_idx_i))
        hss_pkg::REG_TICK_BUDGET:    cfg_d.tick_budget    = cfg_data_i;
        hss_pkg::REG_DWELL_FORWARD:  cfg_d.dwell_forward  = cfg_data_i[hss_pkg::DwellW-1:0];
        hss_pkg::REG_DWELL_BACKWARD: cfg_d.dwell_backward = cfg_data_i[hss_pkg::DwellW-1:0];
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_budget    <= hss_pkg::BudgetReset;
      cfg_q.dwell_forward  <= hss_pkg::DwellReset;
      cfg_q.dwell_backward <= hss_pkg::DwellReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: src/hss_core.sv
// ----------------------------------------------------------------------------
// Half-step sequencer core
// Holds the motion state and computes the next state and result of one word.
// ----------------------------------------------------------------------------
`default_nettype none

module hss_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  hss_pkg::hss_in_t       in_i,
  input  hss_pkg::hss_cfg_t      cfg_i,
  output hss_pkg::hss_res_t      res_o
);

  hss_pkg::hss_mode_e               mode_q, mode_d;
  logic [hss_pkg::PosW-1:0]         pos_q, pos_d;
  logic [hss_pkg::CountW-1:0]       dwell_q, dwell_d;
  logic [hss_pkg::BudgetW-1:0]      tick_q, tick_d;
  logic [hss_pkg::CoilW-1:0]        coil_q, coil_d;

  // Next state for one word: a mode command or a time tick.
  always_comb begin
    hss_pkg::hss_mode_e        req;
    logic                      go_fwd;
    logic                      go_back;
    logic                      budgeted;
    logic                      adv;
    logic [hss_pkg::DwellW-1:0] thr;
    logic [2:0]                idx;

    mode_d  = mode_q;
    pos_d   = pos_q;
    dwell_d = dwell_q;
    tick_d  = tick_q;
    coil_d  = coil_q;
    adv     = 1'b0;

    case (in_i.mode_request)
      3'd1:    req = hss_pkg::MODE_BUD_FWD;
      3'd2:    req = hss_pkg::MODE_BUD_BACK;
      3'd3:    req = hss_pkg::MODE_FREE_FWD;
      3'd4:    req = hss_pkg::MODE_FREE_BACK;
      default: req = hss_pkg::MODE_STOP;
    endcase

    go_fwd   = (mode_q == hss_pkg::MODE_BUD_FWD || mode_q == hss_pkg::MODE_FREE_FWD)
               && in_i.fwd_limit_clear;
    go_back  = (mode_q == hss_pkg::MODE_BUD_BACK || mode_q == hss_pkg::MODE_FREE_BACK)
               && in_i.back_limit_clear;
    budgeted = (mode_q == hss_pkg::MODE_BUD_FWD || mode_q == hss_pkg::MODE_BUD_BACK);
    thr      = go_back ? cfg_i.dwell_backward : cfg_i.dwell_forward;
    idx      = go_back ? ~pos_q[3:1] : pos_q[3:1];

    if (in_i.command) begin
      // A new mode restarts the sequence and the budget.
      if (req != mode_q) begin
        mode_d = req;
        pos_d  = hss_pkg::PosFirst;
        tick_d = '0;
      end
    end else if (go_fwd || go_back) begin
      if (budgeted) begin
        if (tick_q < cfg_i.tick_budget) begin
          tick_d = tick_q + 1'b1;
          adv    = 1'b1;
        end else begin
          // Budget spent: stop, the coils hold this tick.
          mode_d = hss_pkg::MODE_STOP;
        end
      end else begin
        adv = 1'b1;
      end
    end else begin
      coil_d = '0;
      mode_d = hss_pkg::MODE_STOP;
    end

    // Step through the half-step pattern.
    if (adv) begin
      if (pos_q == '0 || pos_q > hss_pkg::PosLast || pos_q == hss_pkg::PosLast) begin
        pos_d = hss_pkg::PosFirst;
      end else if (pos_q[0]) begin
        dwell_d = '0;
        pos_d   = pos_q + 1'b1;
        coil_d  = hss_pkg::phase_coils(idx);
      end else if (dwell_q > {1'b0, thr}) begin
        dwell_d = '0;
        pos_d   = pos_q + 1'b1;
      end else begin
        dwell_d = dwell_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= hss_pkg::MODE_STOP;
      pos_q   <= hss_pkg::PosFirst;
      dwell_q <= '0;
      tick_q  <= '0;
      coil_q  <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      dwell_q <= dwell_d;
      tick_q  <= tick_d;
      coil_q  <= coil_d;
    end
  end

  // The result is the state after this word.
  assign res_o.coils       = coil_d;
  assign res_o.active_mode = mode_d;
  assign res_o.ticks_used  = tick_d;

endmodule

`default_nettype wire

FILE: src/half_step_stepper_sequencer_top.sv
// ----------------------------------------------------------------------------
// Half-step stepper sequencer, top level
// Input register, sequencer core and output register around a stream port.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one word per tick or mode command. tuser is the
//   command flag (0 tick, 1 mode command); tdata holds the mode request and
//   both limit switch flags. The master stream returns one word per input
//   word: coil drive, active mode and ticks counted against the budget.
//   Configuration writes (budget, forward and backward dwell) go through
//   cfg_we_i / cfg_idx_i / cfg_data_i while the block is idle.
//   The accepting edge loads the input register, and the edge that steps
//   the core carries the core result into the output register, where it
//   is offered. Throughput is one word per clock while the receiver does
//   not stall. When the receiver stalls, the output register holds its word
//   and the input register still takes one more word if it is empty; after
//   that tready drops.
//   Reset clears the motion state (stopped, position 1, coils off), restores
//   the register defaults and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module half_step_stepper_sequencer_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Slave stream.
  input  wire logic                         s_axis_tvalid,
  output      logic                         s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,  // mode_request[2:0], fwd_limit_clear, back_limit_clear, zero pad
  input  wire logic                         s_axis_tuser,  // command
  // Master stream.
  output      logic                         m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output      logic [31:0]                  m_axis_tdata,  // coils[3:0], active_mode[2:0], ticks_used[19:0], zero pad
  // Configuration write port.
  input  wire logic                         cfg_we_i,
  input  wire logic [hss_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [hss_pkg::BudgetW-1:0]  cfg_data_i
);

  logic               in_valid_q;
  hss_pkg::hss_in_t   in_q;
  logic               out_valid_q;
  hss_pkg::hss_res_t  out_q;
  logic               step;
  hss_pkg::hss_res_t  res;
  hss_pkg::hss_cfg_t  cfg;

  // A word moves into the core when the output register is free or draining.
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.command          <= s_axis_tuser;
      in_q.mode_request     <= s_axis_tdata[2:0];
      in_q.fwd_limit_clear  <= s_axis_tdata[3];
      in_q.back_limit_clear <= s_axis_tdata[4];
    end
  end

  hss_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  hss_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .in_i   (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q.ticks_used, out_q.active_mode, out_q.coils};

endmodule

`default_nettype wire

FILE: src/hss_checker.sv
// ----------------------------------------------------------------------------
// Half-step sequencer port checker
// Watches the top level ports and checks the result stream over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "half_step_stepper_sequencer_top_macros.svh"

module hss_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  // A stalled result word stays offered and unchanged.
  `HSS_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result word dropped or changed while stalled")

  // Only the eight half-step phases or all-off appear on the coils.
  `HSS_ASSERT(a_coil_phase, clk_i, rst_ni, m_axis_tvalid |-> ($countones(m_axis_tdata[3:0]) <= 2) && (m_axis_tdata[3:0] != 4'h5) && (m_axis_tdata[3:0] != 4'hA), "illegal coil pattern")

  // The active mode is never an undefined code.
  `HSS_ASSERT(a_mode_range, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[6:4] <= 3'd4, "active mode out of range")

  // Free-running modes never count against the budget.
  `HSS_ASSERT(a_free_no_ticks, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[6:4] == 3'd3 || m_axis_tdata[6:4] == 3'd4) |-> m_axis_tdata[26:7] == 20'd0, "ticks counted in a free mode")

  // Held in reset, no result is offered.
  `HSS_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni ##1 !rst_ni |-> !m_axis_tvalid, "result offered during reset")

endmodule

bind half_step_stepper_sequencer_top hss_checker u_hss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
